// ===== sv/xmcs_pkg.sv =====
package xmcs_pkg;

    localparam int unsigned MAX_LEN       = 65536;
    localparam int unsigned BINS          = 256;
    localparam int unsigned BIN_W         = 8;
    localparam int unsigned SEED_W        = 24;
    localparam int unsigned STATE_W       = 64;
    localparam int unsigned COUNT_W       = 17;
    localparam int unsigned SCORE_W       = 31;
    localparam int unsigned SHIFT_A       = 13;
    localparam int unsigned SHIFT_B       = 7;
    localparam int unsigned SHIFT_C       = 17;

    localparam logic [STATE_W-1:0] DEFAULT_STATE = 64'h1234_5678_9ABC_DEF0;
    localparam logic [COUNT_W-1:0] MAX_LEN_C     = COUNT_W'(MAX_LEN);
    localparam logic [SCORE_W-1:0] SCORE_MAX     = {SCORE_W{1'b1}};

    typedef logic [BIN_W-1:0]   bin_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [SCORE_W-1:0] score_t;

    typedef struct packed {
        logic   start;
        logic   active;
        logic   last;
        bin_t   bin;
        count_t byte_count;
        logic   too_long;
    } hist_req_t;

    typedef struct packed {
        logic   valid;
        logic   last;
        score_t score;
        count_t byte_count;
        logic   too_long;
    } hist_stat_t;

    function automatic logic [STATE_W-1:0] xorshift_step(input logic [STATE_W-1:0] x);
        logic [STATE_W-1:0] y;
        y = x ^ (x << SHIFT_A);
        y = y ^ (y >> SHIFT_B);
        y = y ^ (y << SHIFT_C);
        return y;
    endfunction

endpackage

// ===== sv/xmcs_ram.sv =====
module xmcs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/xmcs_mask_gen.sv =====
module xmcs_mask_gen (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           seed_we,
    input  logic [xmcs_pkg::SEED_W-1:0]    seed_wdata,
    input  logic                           start,
    input  logic                           step,
    output logic [xmcs_pkg::BIN_W-1:0]     mask
);

    import xmcs_pkg::*;

    logic [SEED_W-1:0]  seed_reg;
    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;
    logic [STATE_W-1:0] base;
    logic [STATE_W-1:0] first;

    assign base       = start ? ((seed_reg == '0) ? DEFAULT_STATE : STATE_W'(seed_reg))
                              : state_reg;
    assign first      = xorshift_step(base);
    assign state_next = xorshift_step(first);
    assign mask       = first[BIN_W-1:0] | state_next[BIN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg  <= '0;
            state_reg <= DEFAULT_STATE;
        end
        else
        begin
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end
            if (step)
            begin
                state_reg <= state_next;
            end
        end
    end

endmodule

// ===== sv/xmcs_hist.sv =====
module xmcs_hist (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   issue,
    input  xmcs_pkg::hist_req_t    req,
    input  logic                   hold,
    output xmcs_pkg::hist_stat_t   stat
);

    import xmcs_pkg::*;

    hist_req_t         b_reg;
    logic              b_valid_reg;
    logic [BINS-1:0]   valid_reg;
    logic              fwd_valid_reg;
    bin_t              fwd_bin_reg;
    count_t            fwd_count_reg;
    score_t            score_reg;

    count_t            rdata;
    count_t            prev;
    count_t            count;
    count_t            count_next;
    score_t            score_base;
    logic [SCORE_W:0]  sum;
    score_t            score_next;
    logic              advance;
    logic              we;

    xmcs_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (BINS)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (b_reg.bin),
        .wdata (count_next),
        .re    (issue && req.active),
        .raddr (req.bin),
        .rdata (rdata)
    );

    always_comb
    begin
        prev       = (fwd_valid_reg && (fwd_bin_reg == b_reg.bin)) ? fwd_count_reg : rdata;
        count      = (b_reg.start || !valid_reg[b_reg.bin]) ? '0 : prev;
        count_next = count + COUNT_W'(1);
        score_base = b_reg.start ? '0 : score_reg;
        sum        = {1'b0, score_base} + (SCORE_W+1)'(count);
        if (!b_reg.active)
        begin
            score_next = score_base;
        end
        else if (sum > (SCORE_W+1)'(SCORE_MAX))
        begin
            score_next = SCORE_MAX;
        end
        else
        begin
            score_next = sum[SCORE_W-1:0];
        end
    end

    assign advance = b_valid_reg && !hold;
    assign we      = advance && b_reg.active;

    assign stat.valid      = b_valid_reg;
    assign stat.last       = b_reg.last;
    assign stat.score      = score_next;
    assign stat.byte_count = b_reg.byte_count;
    assign stat.too_long   = b_reg.too_long;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            valid_reg     <= '0;
            fwd_valid_reg <= 1'b0;
            score_reg     <= '0;
        end
        else
        begin
            b_valid_reg <= issue || (b_valid_reg && hold);
            if (advance)
            begin
                score_reg <= score_next;
            end
            if (we)
            begin
                fwd_valid_reg <= 1'b1;
                if (b_reg.start)
                begin
                    valid_reg <= BINS'(1) << b_reg.bin;
                end
                else
                begin
                    valid_reg[b_reg.bin] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            b_reg <= req;
        end
        if (we)
        begin
            fwd_bin_reg   <= b_reg.bin;
            fwd_count_reg <= count_next;
        end
    end

endmodule

// ===== sv/xorshift_mask_collision_score.sv =====
// Channel   Dir  Beat fields (lowest bit first)
// s_axis    in   tdata: data_byte[7:0]; tlast: last
// m_axis    out  tdata: score[30:0], byte_count[47:31], too_long[48], zero pad to 56
// cfg       in   cfg_wdata: seed[23:0], written when cfg_we is high
//
// One byte per cycle while s_tready is high: the histogram RAM is read at accept and
// written when the b stage advances, with the last write forwarded to the following read.
// A last byte holds while the result register is full and m_tready is low.
// Reset is asynchronous; bin valid bits clear at reset and at each run start, so the
// histogram RAM needs no clearing pass.
module xorshift_mask_collision_score (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [xmcs_pkg::SEED_W-1:0]   cfg_wdata,   // seed
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,     // data_byte
    input  logic                          s_tlast,     // last
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [55:0]                   m_tdata      // score, byte_count, too_long
);

    import xmcs_pkg::*;

    logic        issue;
    logic        hold;
    logic        start;
    logic        active;
    count_t      byte_count;
    logic        too_long;
    bin_t        mask;
    hist_req_t   req;
    hist_stat_t  stat;

    count_t      run_len_reg;
    count_t      run_len_next;
    logic        ovf_reg;
    logic        ovf_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    score_t      out_score_reg;
    count_t      out_count_reg;
    logic        out_too_long_reg;
    logic        load;

    assign hold     = stat.valid && stat.last && out_valid_reg && !m_tready;
    assign s_tready = !hold;
    assign issue    = s_tvalid && s_tready;

    assign start      = (run_len_reg == '0);
    assign active     = (run_len_reg < MAX_LEN_C);
    assign byte_count = active ? (run_len_reg + COUNT_W'(1)) : run_len_reg;
    assign too_long   = ovf_reg || !active;

    xmcs_mask_gen u_mask_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .seed_we    (cfg_we),
        .seed_wdata (cfg_wdata),
        .start      (start),
        .step       (issue && active),
        .mask       (mask)
    );

    assign req.start      = start;
    assign req.active     = active;
    assign req.last       = s_tlast;
    assign req.bin        = s_tdata + mask;
    assign req.byte_count = byte_count;
    assign req.too_long   = too_long;

    xmcs_hist u_hist (
        .clk   (clk),
        .rst_n (rst_n),
        .issue (issue),
        .req   (req),
        .hold  (hold),
        .stat  (stat)
    );

    always_comb
    begin
        run_len_next = run_len_reg;
        ovf_next     = ovf_reg;
        if (issue)
        begin
            run_len_next = s_tlast ? '0 : byte_count;
            ovf_next     = s_tlast ? 1'b0 : too_long;
        end
    end

    assign load           = stat.valid && stat.last && !hold;
    assign out_valid_next = (out_valid_reg && !m_tready) || load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_len_reg   <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            run_len_reg   <= run_len_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_score_reg    <= stat.score;
            out_count_reg    <= stat.byte_count;
            out_too_long_reg <= stat.too_long;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0, out_too_long_reg, out_count_reg, out_score_reg};

endmodule

// ===== dv/xorshift_mask_collision_score_test.sv =====
`timescale 1ns / 100ps

module xorshift_mask_collision_score_test;

    import xmcs_pkg::*;

    localparam int LIMIT      = 1_000_000;
    localparam int RAND_BYTES = 1100;
    localparam int SETTLE     = 8;
    localparam int NROWS      = 18;

    typedef struct packed {
        score_t score;
        count_t byte_count;
        logic   too_long;
    } scored_run_t;

    typedef struct packed {
        bin_t              data;
        logic              last;
        logic              set_seed;
        logic [SEED_W-1:0] seed;
        logic              typed;
        scored_run_t       result;
    } step_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SEED_W-1:0] cfg_wdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [7:0]        s_tdata;     // data_byte
    logic              s_tlast;     // last
    logic              m_tvalid;
    logic              m_tready;
    logic [55:0]       m_tdata;     // score[30:0], byte_count[47:31], too_long[48], pad

    // mirror of the block's state
    logic [SEED_W-1:0]  seed_reg;
    logic [STATE_W-1:0] prng;
    count_t             bin_hist [BINS];
    longint             run_score;
    int                 run_len;
    logic               run_over;

    scored_run_t pending_scores [$];
    step_row_t   plan [0:NROWS-1];

    int  errors;
    int  cycles;
    int  bytes_sent;
    int  runs_checked;
    int  seed_writes;
    bit  src_idle;
    bit  stall_on;
    int  sink_left;

    xorshift_mask_collision_score u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic logic [SEED_W-1:0] pick_seed();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 24'd1;
            default: return SEED_W'($urandom);
        endcase
    endfunction

    function automatic logic [STATE_W-1:0] xs_next(input logic [STATE_W-1:0] v);
        logic [STATE_W-1:0] w;
        w = v ^ (v << SHIFT_A);
        w = w ^ (w >> SHIFT_B);
        w = w ^ (w << SHIFT_C);
        return w;
    endfunction

    task automatic score_byte(input bin_t data, input logic last,
                              output logic done, output scored_run_t res);
        logic [STATE_W-1:0] m1;
        logic [STATE_W-1:0] m2;
        bin_t               slot;
        longint             sum;
        if (run_len == 0)
        begin
            prng = (seed_reg != '0) ? STATE_W'(seed_reg) : DEFAULT_STATE;
            foreach (bin_hist[i])
                bin_hist[i] = '0;
            run_score = 0;
            run_over  = 1'b0;
        end
        if (run_len < MAX_LEN)
        begin
            prng = xs_next(prng);
            m1   = prng;
            prng = xs_next(prng);
            m2   = prng;
            slot = data + (m1[7:0] | m2[7:0]);
            sum  = run_score + bin_hist[slot];
            if (sum > longint'(SCORE_MAX))
                sum = longint'(SCORE_MAX);
            run_score      = sum;
            bin_hist[slot] = bin_hist[slot] + 1'b1;
            run_len++;
        end
        else
            run_over = 1'b1;
        done = last;
        res  = '{score: score_t'(run_score), byte_count: count_t'(run_len),
                 too_long: run_over};
        if (last)
            run_len = 0;
    endtask

    task automatic send_byte(input bin_t data, input logic last,
                             input logic typed, input scored_run_t typed_res);
        int          gap;
        logic        done;
        scored_run_t res;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        score_byte(data, last, done, res);
        if (done)
            pending_scores.push_back(typed ? typed_res : res);
        bytes_sent++;
    endtask

    task automatic send_run(input int len);
        for (int i = 1; i <= len; i++)
            send_byte(bin_t'($urandom), i == len, 1'b0, '0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_scores.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_seed(input logic [SEED_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        seed_reg  = v;
        seed_writes++;
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    // sink: random back-pressure while stall_on is set, else always ready
    always @(posedge clk)
    begin
        if (sink_left > 0)
            sink_left--;
        else if (!stall_on || $urandom_range(0, 2) != 0)
        begin
            m_tready <= 1'b1;
            sink_left = stall_on ? $urandom_range(0, 15) : 0;
        end
        else
        begin
            m_tready <= 1'b0;
            sink_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        scored_run_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_scores.size() == 0)
            begin
                $display("%0t: unexpected result beat, got %0h", $time, m_tdata);
                errors++;
            end
            else
            begin
                want = pending_scores.pop_front();
                check_field("score", 64'(want.score), 64'(m_tdata[30:0]));
                check_field("byte_count", 64'(want.byte_count), 64'(m_tdata[47:31]));
                check_field("too_long", 64'(want.too_long), 64'(m_tdata[48]));
                check_field("pad", 64'd0, 64'(m_tdata[55:49]));
                runs_checked++;
            end
        end
    end

    initial
    begin
        int len;
        int r;

        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        errors    = 0;
        cycles    = 0;
        sink_left = 0;
        src_idle  = 1'b1;
        stall_on  = 1'b1;
        seed_reg  = '0;
        run_len   = 0;
        run_over  = 1'b0;
        run_score = 0;

        //        data   last  wr    seed        typed  score  count  over
        plan = '{
            '{8'h00, 1'b1, 1'b0, 24'h000000, 1'b1, '{31'd0, 17'd1, 1'b0}},
            '{8'hFF, 1'b1, 1'b0, 24'h000000, 1'b1, '{31'd0, 17'd1, 1'b0}},
            '{8'h80, 1'b0, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h7F, 1'b0, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h55, 1'b0, 1'b0, 24'h000000, 1'b0, '0},
            '{8'hAA, 1'b1, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h00, 1'b1, 1'b1, 24'hFFFFFF, 1'b1, '{31'd0, 17'd1, 1'b0}},
            '{8'h3C, 1'b0, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h3C, 1'b0, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h3C, 1'b1, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h12, 1'b0, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h34, 1'b0, 1'b1, 24'h000001, 1'b0, '0},
            '{8'h56, 1'b1, 1'b0, 24'h000000, 1'b0, '0},
            '{8'hFF, 1'b1, 1'b0, 24'h000000, 1'b1, '{31'd0, 17'd1, 1'b0}},
            '{8'h01, 1'b0, 1'b1, 24'h000000, 1'b0, '0},
            '{8'h01, 1'b0, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h01, 1'b1, 1'b0, 24'h000000, 1'b0, '0},
            '{8'h5A, 1'b1, 1'b1, 24'h800000, 1'b1, '{31'd0, 17'd1, 1'b0}}
        };

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NROWS; i++)
        begin
            if (plan[i].set_seed)
                write_seed(plan[i].seed);
            send_byte(plan[i].data, plan[i].last, plan[i].typed, plan[i].result);
        end

        // full-length run, then two past the limit; hold both sides busy
        src_idle = 1'b0;
        stall_on = 1'b0;
        write_seed(pick_seed());
        send_run(MAX_LEN);
        send_run(MAX_LEN + 2);
        src_idle = 1'b1;
        stall_on = 1'b1;

        len = bytes_sent;
        while (bytes_sent - len < RAND_BYTES)
        begin
            if ($urandom_range(0, 4) == 0)
                write_seed(pick_seed());
            r        = $urandom_range(0, 4);
            src_idle = (r != 0);
            stall_on = (r != 1);
            r = $urandom_range(0, 99);
            if (r < 70)
                send_run($urandom_range(1, 12));
            else if (r < 95)
                send_run($urandom_range(13, 64));
            else
                send_run($urandom_range(65, 300));
        end

        drain();
        $display("Sent %0d bytes over %0d seed settings; %0d run scores checked,",
                 bytes_sent, seed_writes + 1, runs_checked);
        $display("including a full-length run, an over-length run and a mid-run seed change.");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/xmcs_pkg.sv
sv/xmcs_ram.sv
sv/xmcs_mask_gen.sv
sv/xmcs_hist.sv
sv/xorshift_mask_collision_score.sv
dv/xorshift_mask_collision_score_test.sv
